[hdl/sdc_pkg.sv]
// Shared constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
package sdc_pkg;

   // Width of the request value field on the channel
   localparam int VALUE_BITS = 64;
   // Default number of low value bits that take part in the conversion
   localparam int VALUE_WIDTH_DEFAULT = 64;
   // Width of one character on the response channel
   localparam int CHAR_BITS = 8;
   // Width of one packed BCD digit
   localparam int DIGIT_BITS = 4;

   // Character codes
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

endpackage

[hdl/sdc_if.sv]
// Request and response channel interfaces for the decimal ASCII converter.
`timescale 1ns / 1ps
interface sdc_req_if;
   logic                           valid;
   logic                           ready;
   logic [sdc_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sdc_pkg::CHAR_BITS-1:0] char_code;
   logic                          last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

[hdl/signed_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, one character per response.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    value[63:0], low VALUE_WIDTH bits used, signed
//   rsp_chan  out  valid/ready    char_code[7:0], last
//
// One request is loaded, converted in the shift-add-3 unit one magnitude bit
// at a time and stripped of its leading zero digits; it is then sent as one
// character per taken response, with a minus sign first for a negative value.
// Reset returns the sequencer to idle; no clearing pass is needed.
// A stalled response holds its character; req_chan.ready is low until the
// character with last set has been taken.
`timescale 1ns / 1ps
module signed_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sdc_req_if.sink   req_chan,
   sdc_rsp_if.source rsp_chan
);

   // Decimal digits needed for any VALUE_WIDTH-bit unsigned magnitude
   localparam int DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DW        = sdc_pkg::DIGIT_BITS;
   localparam int BCD_W     = DIGITS * DW;
   localparam int BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int DIG_CNT_W = $clog2(DIGITS + 1);

   localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_WIDTH - 1);
   localparam logic [DIG_CNT_W-1:0] ALL_DIGITS = DIG_CNT_W'(DIGITS);
   localparam logic [DIG_CNT_W-1:0] ONE_DIGIT  = DIG_CNT_W'(1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SKIP = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] raw_mag;
   logic [BCD_W-1:0]       bcd_step;
   logic [DW-1:0]          top_digit;
   logic                   req_fire;
   logic                   rsp_fire;

   // Take the used bits and form the unsigned magnitude
   assign raw     = req_chan.value[VALUE_WIDTH-1:0];
   assign raw_mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

   assign top_digit = bcd_ff[BCD_W-1 -: DW];
   assign req_fire  = req_chan.valid & req_chan.ready;
   assign rsp_fire  = rsp_chan.valid & rsp_chan.ready;

   // Shared shift-add-3 unit, one magnitude bit per cycle
   sdc_dabble_step #(
      .DIGITS (DIGITS)
   ) u_step (
      .bcd_i (bcd_ff),
      .bit_i (mag_ff[VALUE_WIDTH-1]),
      .bcd_o (bcd_step)
   );

   // Drive the channels from registered state
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_SIGN) | (state_ff == ST_EMIT);
   assign rsp_chan.char_code = (state_ff == ST_SIGN) ? sdc_pkg::ASCII_MINUS
                               : sdc_pkg::ASCII_ZERO + {{(sdc_pkg::CHAR_BITS-DW){1'b0}}, top_digit};
   assign rsp_chan.last      = (state_ff == ST_EMIT) && (dig_cnt_ff == ONE_DIGIT);

   // Sequence load, conversion, leading zero drop and character output
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_in     = raw_mag;
               neg_in     = raw[VALUE_WIDTH-1];
               bcd_in     = '0;
               bit_cnt_in = LAST_BIT;
               dig_cnt_in = ALL_DIGITS;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = ST_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_SKIP: begin
            // Drop leading zeros, keeping at least one digit
            if ((top_digit == '0) && (dig_cnt_ff != ONE_DIGIT)) begin
               bcd_in     = {bcd_ff[BCD_W-DW-1:0], {DW{1'b0}}};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (rsp_fire) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Advance to the next digit once the character is taken
            if (rsp_fire) begin
               bcd_in     = {bcd_ff[BCD_W-DW-1:0], {DW{1'b0}}};
               dig_cnt_in = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == ONE_DIGIT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

endmodule

[hdl/sdc_dabble_step.sv]
// One shift-add-3 step of binary to BCD conversion over a row of digits.
`timescale 1ns / 1ps
module sdc_dabble_step #(
   parameter int DIGITS = 20
) (
   input  logic [DIGITS*sdc_pkg::DIGIT_BITS-1:0] bcd_i,
   input  logic                                  bit_i,
   output logic [DIGITS*sdc_pkg::DIGIT_BITS-1:0] bcd_o
);

   localparam int BCD_W = DIGITS * sdc_pkg::DIGIT_BITS;
   localparam int DW    = sdc_pkg::DIGIT_BITS;

   logic [BCD_W-1:0] adjusted;

   // Correct every digit of five or more so the doubling carries in decimal
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_i[d*DW +: DW] >= 4'd5) begin
            adjusted[d*DW +: DW] = bcd_i[d*DW +: DW] + 4'd3;
         end else begin
            adjusted[d*DW +: DW] = bcd_i[d*DW +: DW];
         end
      end
   end

   // Double and bring in the next magnitude bit
   assign bcd_o = {adjusted[BCD_W-2:0], bit_i};

endmodule

[sim/tb_signed_to_decimal_ascii.sv]
// Testbench for signed_to_decimal_ascii: directed table, then random requests checked per char.
`timescale 1ns / 1ps
module tb_signed_to_decimal_ascii;

   // Conversion width of the instance (its default)
   localparam int CONV_WIDTH = sdc_pkg::VALUE_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int DIRECTED_ROWS = 20;

   typedef struct packed {
      logic [sdc_pkg::CHAR_BITS-1:0] char_code;
      logic                          last;
   } expected_char_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SLOW} sink_mode_type;
   typedef enum logic [1:0] {VAL_ANY, VAL_DIGITS, VAL_DECADE, VAL_EDGE} value_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           src_valid = 1'b0;
   logic [sdc_pkg::VALUE_BITS-1:0] src_value = '0;
   logic                           sink_ready = 1'b0;

   sdc_req_if req_bus ();
   sdc_rsp_if rsp_bus ();

   assign req_bus.valid = src_valid;
   assign req_bus.value = src_value;
   assign rsp_bus.ready = sink_ready;

   signed_to_decimal_ascii uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   expected_char_type char_queue[$];
   expected_char_type char_front;
   int                error_count = 0;
   int                burst_left = 0;

   // Directed table: an empty text means the row is checked against decimal_text
   logic [sdc_pkg::VALUE_BITS-1:0] dir_value [DIRECTED_ROWS] = '{
      64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'd1000000000000000000, -64'sd1000000000000000000, 64'd999999999999999999,
      64'd123456789, -64'sd987654321,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
   };
   string dir_text [DIRECTED_ROWS] = '{
      "0", "1", "-1", "9", "10", "-10", "99", "100",
      "9223372036854775807", "-9223372036854775808", "-9223372036854775807",
      "1000000000000000000", "", "",
      "123456789", "-987654321",
      "", "", "", ""
   };

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Print one mismatch line and count it
   task automatic flag_error(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // Decimal text of the low CONV_WIDTH bits, taken as signed
   function automatic string decimal_text(input logic [sdc_pkg::VALUE_BITS-1:0] value_in);
      logic [sdc_pkg::VALUE_BITS-1:0] mask;
      logic [sdc_pkg::VALUE_BITS-1:0] raw;
      logic [sdc_pkg::VALUE_BITS-1:0] mag;
      logic [sdc_pkg::VALUE_BITS-1:0] digit;
      logic                           negative;
      string                          text;
      mask = {sdc_pkg::VALUE_BITS{1'b1}} >> (sdc_pkg::VALUE_BITS - CONV_WIDTH);
      raw = value_in & mask;
      negative = raw[CONV_WIDTH-1];
      mag = negative ? ((~raw + 1'b1) & mask) : raw;
      text = "";
      // Peel digits least significant first, prepend each
      do begin
         digit = mag % 64'd10;
         text = {" ", text};
         text[0] = sdc_pkg::ASCII_ZERO + digit[sdc_pkg::CHAR_BITS-1:0];
         mag = mag / 64'd10;
      end while (mag != 0);
      if (negative) text = {"-", text};
      return text;
   endfunction

   // Offer one request in bursts with random gaps, queue its characters on accept
   task automatic send_value(input logic [sdc_pkg::VALUE_BITS-1:0] value, input string typed);
      string             text;
      expected_char_type one;
      int                gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      src_valid <= 1'b1;
      src_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      text = (typed.len() != 0) ? typed : decimal_text(value);
      for (int i = 0; i < text.len(); i++) begin
         one.char_code = text[i];
         one.last = (i == text.len() - 1);
         char_queue.push_back(one);
      end
      @(negedge clock);
   endtask

   // Receiver: pick a new random stall mode each time the hold count runs out
   sink_mode_type sink_mode = SINK_OPEN;
   logic [7:0]    sink_pattern = 8'hFF;
   int            sink_hold = 0;

   always @(negedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_pattern <= 8'($urandom) | 8'h01;
         sink_hold <= $urandom_range(20, 120);
      end else begin
         sink_pattern <= {sink_pattern[6:0], sink_pattern[7]};
         sink_hold <= sink_hold - 1;
      end
      case (sink_mode)
         SINK_OPEN: sink_ready <= 1'b1;
         SINK_COIN: sink_ready <= 1'($urandom_range(0, 1));
         SINK_PATTERN: sink_ready <= sink_pattern[0];
         default: sink_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Compare each taken character with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && sink_ready) begin
         if (char_queue.size() == 0) begin
            flag_error($sformatf("unexpected char %0d last %0b",
                                 rsp_bus.char_code, rsp_bus.last));
         end else begin
            char_front = char_queue.pop_front();
            if (rsp_bus.char_code !== char_front.char_code)
               flag_error($sformatf("char_code %0d, expected %0d",
                                    rsp_bus.char_code, char_front.char_code));
            if (rsp_bus.last !== char_front.last)
               flag_error($sformatf("last %0b on char %0d, expected %0b",
                                    rsp_bus.last, char_front.char_code, char_front.last));
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [sdc_pkg::VALUE_BITS-1:0] raw;
      logic [sdc_pkg::VALUE_BITS-1:0] value;
      logic [sdc_pkg::VALUE_BITS-1:0] decade;
      value_kind_type                 kind;
      int                             pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Walk the directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) send_value(dir_value[r], dir_text[r]);

      // Random requests, shaped toward every digit count and decade edges
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         raw = {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         kind = (pick < 3) ? VAL_ANY : (pick < 7) ? VAL_DIGITS : (pick < 9) ? VAL_DECADE
                : VAL_EDGE;
         case (kind)
            VAL_ANY: value = raw;
            VAL_DIGITS: begin
               value = raw >> $urandom_range(0, 63);
               if ($urandom_range(0, 1) == 1) value = -value;
            end
            VAL_DECADE: begin
               decade = 64'd1;
               repeat ($urandom_range(0, 18)) decade = decade * 64'd10;
               value = decade + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1) == 1) value = -value;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: value = 64'h8000_0000_0000_0000;
                  1: value = 64'h7FFF_FFFF_FFFF_FFFF;
                  2: value = 64'd0;
                  3: value = 64'd1;
                  default: value = {sdc_pkg::VALUE_BITS{1'b1}};
               endcase
            end
         endcase
         send_value(value, "");
      end
      src_valid <= 1'b0;

      // Drain, then allow the conversion latency for stray characters
      while (char_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && char_queue.size() == 0) begin
         $display("PASS signed_to_decimal_ascii");
      end else begin
         $display("FAIL signed_to_decimal_ascii");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2000000;
      $display("FAIL signed_to_decimal_ascii");
      $finish;
   end

endmodule

[files.f]
hdl/sdc_pkg.sv
hdl/sdc_if.sv
hdl/sdc_dabble_step.sv
hdl/signed_to_decimal_ascii.sv
sim/tb_signed_to_decimal_ascii.sv
